// ----- rtl/mks_pkg.sv -----
package mks_pkg;

    // sequencer geometry and timing
    localparam int STEP_COUNT  = 6;
    localparam int TABLE_ROWS  = 8;
    localparam int STEP_W      = 3;
    localparam int CNT_W       = 14;
    localparam int TMO_W       = 13;
    localparam int RETRY_W     = 3;
    localparam int AT_W        = 3;

    localparam logic [CNT_W-1:0] TICK_MS         = CNT_W'(100);
    localparam logic [CNT_W-1:0] REPLY_MARGIN_MS = CNT_W'(100);
    localparam logic [CNT_W-1:0] MIN_WAIT_MS     = CNT_W'(10);

    // steps with special handling
    localparam logic [STEP_W-1:0] DISABLE_STEP = STEP_W'(0);
    localparam logic [STEP_W-1:0] ENABLE_STEP  = STEP_W'(1);
    localparam logic [STEP_W-1:0] SIM_STEP     = STEP_W'(4);

    // input word kinds
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_DISABLE = 2'd1,
        ACT_ENABLE  = 2'd2,
        ACT_SEND_AT = 2'd3
    } t_action;

    typedef enum logic [AT_W-1:0] {
        AT_NONE   = 3'd0,
        AT_PLAIN  = 3'd1,
        AT_ECHO   = 3'd2,
        AT_SIMPIN = 3'd3,
        AT_CSQ    = 3'd4
    } t_at_cmd;

    typedef struct packed {
        t_at_cmd             at;
        logic                kind;
        logic                arg;
        logic [RETRY_W-1:0]  retries;
        logic [CNT_W-1:0]    reply_limit;
        logic [CNT_W-1:0]    wait_ms;
        logic [STEP_W-1:0]   next_ok;
        logic [STEP_W-1:0]   next_fail;
    } t_row;

    typedef struct packed {
        t_action             action;
        t_at_cmd             at_command;
        logic                access_kind;
        logic                command_argument;
        logic [TMO_W-1:0]    reply_timeout_ms;
        logic [STEP_W-1:0]   current_step;
    } t_result;

    // step table, rows past the last step are empty
    function automatic t_row row_of(input logic [STEP_W-1:0] s);
        t_row r;
        case (s)
            3'd0:    r = '{AT_NONE,   1'b0, 1'b0, 3'd1, 14'd0,    14'd100,  3'd1, 3'd0};
            3'd1:    r = '{AT_NONE,   1'b0, 1'b0, 3'd1, 14'd5000, 14'd5000, 3'd2, 3'd0};
            3'd2:    r = '{AT_PLAIN,  1'b0, 1'b0, 3'd1, 14'd1100, 14'd100,  3'd3, 3'd0};
            3'd3:    r = '{AT_ECHO,   1'b1, 1'b1, 3'd1, 14'd1100, 14'd100,  3'd4, 3'd1};
            3'd4:    r = '{AT_SIMPIN, 1'b0, 1'b0, 3'd3, 14'd2000, 14'd100,  3'd5, 3'd0};
            3'd5:    r = '{AT_CSQ,    1'b0, 1'b0, 3'd1, 14'd1100, 14'd5000, 3'd4, 3'd4};
            default: r = '{AT_NONE,   1'b0, 1'b0, 3'd0, 14'd0,    14'd0,    3'd0, 3'd0};
        endcase
        return r;
    endfunction

    // out-of-range steps fall back to the first step
    function automatic logic [STEP_W-1:0] legal_step(input logic [STEP_W-1:0] s);
        return ((32'(s) >= STEP_COUNT) || (32'(s) >= TABLE_ROWS)) ? '0 : s;
    endfunction

    function automatic logic [CNT_W-1:0] sub_sat(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [CNT_W-1:0] wait_of(input logic [STEP_W-1:0] s);
        t_row r;
        r = row_of(s);
        return (r.wait_ms == '0) ? MIN_WAIT_MS : r.wait_ms;
    endfunction

endpackage

// ----- rtl/modem_keepalive_sequencer.sv -----
// Table-driven modem bring-up and keepalive sequencer. Each input word is either
// a tick (i_in_cmd = 0, one 100 ms period) or a reply event (i_in_cmd = 1, with
// i_in_reply_matched telling whether the reply was the one the current step
// expects). Every accepted word yields exactly one result word, in order: the
// action to take (none, disable module, enable module, send AT command), the
// command fields for an AT command, and the step index afterwards. Each accepted
// word's result goes to the result register, or to the skid entry while the
// output is stalled, and a new word is accepted every cycle while o_in_stall is
// low; the step, countdown and retry registers update together on acceptance.
// A two-entry output stage (result register plus skid) takes one word past a stall.
// Ticks are ignored while i_cfg_wr_data last written was 0 (reset value);
// reply events are recorded regardless.
module modem_keepalive_sequencer
    import mks_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_in_cmd,
    input  logic                 i_in_reply_matched,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_out_action,
    output logic [AT_W-1:0]      o_out_at_command,
    output logic                 o_out_access_kind,
    output logic                 o_out_command_argument,
    output logic [TMO_W-1:0]     o_out_reply_timeout_ms,
    output logic [STEP_W-1:0]    o_out_current_step
);

    // sequencer state
    logic                    r_run_en;
    logic [STEP_W-1:0]       r_step,      n_step;
    logic [CNT_W-1:0]        r_reply_cd,  n_reply_cd;
    logic [CNT_W-1:0]        r_wait_cd,   n_wait_cd;
    logic [RETRY_W-1:0]      r_retries,   n_retries;
    logic                    r_reply_seen, n_reply_seen;
    logic [TABLE_ROWS-1:0]   r_succ,      n_succ;

    // output stage
    t_result                 r_out, r_skid, res;
    logic                    r_out_valid, r_skid_valid;

    logic                    in_acc, out_take;
    logic                    ld_out_in, ld_out_skid, ld_skid;
    logic [STEP_W-1:0]       s;
    t_row                    row;
    logic                    go;
    logic [CNT_W-1:0]        wait_dec;
    logic                    succ_now;
    logic [RETRY_W-1:0]      ret_now;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    // next state and result for one word
    always_comb begin
        s            = legal_step(r_step);
        row          = row_of(s);
        go           = 1'b0;
        wait_dec     = sub_sat(r_wait_cd, TICK_MS);
        succ_now     = r_succ[s];
        ret_now      = r_retries;
        n_step       = s;
        n_reply_cd   = r_reply_cd;
        n_wait_cd    = r_wait_cd;
        n_retries    = r_retries;
        n_reply_seen = r_reply_seen;
        n_succ       = r_succ;
        res          = '0;
        res.action   = ACT_NONE;
        res.at_command = AT_NONE;

        if (i_in_cmd == CMD_REPLY) begin
            n_reply_seen = 1'b1;
            if (i_in_reply_matched) begin
                n_succ[s] = 1'b1;
            end
        end else if (r_run_en) begin
            go = 1'b1;
            // reply timeout runs while no reply is in
            if (!r_reply_seen) begin
                if (r_reply_cd != '0) begin
                    n_reply_cd = sub_sat(r_reply_cd, TICK_MS);
                    go = 1'b0;
                end
            end else begin
                n_reply_cd = '0;
            end
            // inter-step wait, reload retries when it runs out
            if (go && (r_wait_cd != '0)) begin
                n_wait_cd = wait_dec;
                if (wait_dec == '0) begin
                    ret_now   = row.retries;
                    n_retries = row.retries;
                    succ_now  = 1'b0;
                    n_succ[s] = 1'b0;
                end else begin
                    go = 1'b0;
                end
            end
            if (go) begin
                if (succ_now) begin
                    n_wait_cd = wait_of(s);
                    n_step    = legal_step(row.next_ok);
                end else if (ret_now == '0) begin
                    n_wait_cd = wait_of(s);
                    if (s == SIM_STEP) begin
                        n_retries = RETRY_W'(1);
                    end
                    n_step = legal_step(row.next_fail);
                end else begin
                    n_retries    = ret_now - RETRY_W'(1);
                    n_reply_seen = 1'b0;
                    n_reply_cd   = row.reply_limit;
                    if (s == DISABLE_STEP) begin
                        n_reply_seen = 1'b1;
                        n_succ[DISABLE_STEP] = 1'b1;
                        res.action = ACT_DISABLE;
                    end else if (s == ENABLE_STEP) begin
                        res.action = ACT_ENABLE;
                    end else begin
                        res.action           = ACT_SEND_AT;
                        res.at_command       = row.at;
                        res.access_kind      = row.kind;
                        res.command_argument = row.arg;
                        res.reply_timeout_ms =
                            TMO_W'(sub_sat(row.reply_limit, REPLY_MARGIN_MS));
                    end
                end
            end
        end
        res.current_step = n_step;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_en     <= 1'b0;
            r_step       <= '0;
            r_reply_cd   <= '0;
            r_wait_cd    <= '0;
            r_retries    <= '0;
            r_reply_seen <= 1'b0;
            r_succ       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_run_en <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_step       <= n_step;
                r_reply_cd   <= n_reply_cd;
                r_wait_cd    <= n_wait_cd;
                r_retries    <= n_retries;
                r_reply_seen <= n_reply_seen;
                r_succ       <= n_succ;
            end
        end
    end

    // output register and skid entry
    assign ld_out_skid = out_take && r_skid_valid;
    assign ld_out_in   = in_acc && (!r_out_valid || out_take);
    assign ld_skid     = in_acc && r_out_valid && !out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= ld_out_in || ld_out_skid || (r_out_valid && !out_take);
            r_skid_valid <= ld_skid || (r_skid_valid && !ld_out_skid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out_skid) begin
            r_out <= r_skid;
        end else if (ld_out_in) begin
            r_out <= res;
        end
        if (ld_skid) begin
            r_skid <= res;
        end
    end

    assign o_in_stall             = r_skid_valid;
    assign o_out_valid            = r_out_valid;
    assign o_out_action           = r_out.action;
    assign o_out_at_command       = r_out.at_command;
    assign o_out_access_kind      = r_out.access_kind;
    assign o_out_command_argument = r_out.command_argument;
    assign o_out_reply_timeout_ms = r_out.reply_timeout_ms;
    assign o_out_current_step     = r_out.current_step;

    // skid entry is only ever used behind a full result register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while result register empty");

    // step index stays inside the table
    a_step_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_step) < STEP_COUNT)
        else $error("step index out of range");

    // a reply word always marks the reply as seen
    a_reply_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_cmd == CMD_REPLY)) |=> r_reply_seen)
        else $error("reply word not recorded");

    // command fields are zero unless an at command goes out
    a_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action != ACT_SEND_AT)) |->
            ((r_out.at_command == AT_NONE) && (r_out.reply_timeout_ms == '0)))
        else $error("command fields set without at command");

    // retry count never exceeds the largest reload
    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retries <= RETRY_W'(3))
        else $error("retry count out of range");

endmodule
